@@ hdl/bsc_pkg.sv @@
`default_nettype none

package bsc_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_SENS      = 3'd0;
	localparam logic [2:0] REG_OFF       = 3'd1;
	localparam logic [2:0] REG_SENS_TC   = 3'd2;
	localparam logic [2:0] REG_OFF_TC    = 3'd3;
	localparam logic [2:0] REG_TREF      = 3'd4;
	localparam logic [2:0] REG_TEMP_SENS = 3'd5;
	localparam logic [2:0] REG_SO_EN     = 3'd6;

	localparam int IN_W   = 24;  // raw conversion port width
	localparam int DT_W   = 25;  // signed dT
	localparam int TEMP_W = 20;  // signed temperature in 0.01 degC
	localparam int OS_W   = 40;  // signed OFF / SENS and their corrections
	localparam int P_W    = 24;  // pressure output

	localparam logic signed [TEMP_W-1:0] TEMP_REF      = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_VERY_LOW = -20'sd1500;
	localparam logic [P_W-1:0]           PRESSURE_MAX  = 24'hFFFFFF;

	// Calibration registers seen by the datapath
	typedef struct packed {
		logic [15:0] sens;
		logic [15:0] off;
		logic [15:0] sens_tc;
		logic [15:0] off_tc;
		logic [15:0] tref;
		logic [15:0] temp_sens;
		logic        so_en;
	} cal_cfg_t;

	// First-order results
	typedef struct packed {
		logic [IN_W-1:0]          d1;
		logic signed [TEMP_W-1:0] temp;
		logic [TEMP_W-1:0]        t2;
		logic signed [OS_W-1:0]   off;
		logic signed [OS_W-1:0]   sens;
	} fo_t;

	// Results after the low-temperature corrections
	typedef struct packed {
		logic [IN_W-1:0]          d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OS_W-1:0]   off;
		logic signed [OS_W-1:0]   sens;
	} so_t;

	// Output beat
	typedef struct packed {
		logic [P_W-1:0]           pressure;
		logic signed [TEMP_W-1:0] temp;
		logic                     sat;
	} res_t;

endpackage

`default_nettype wire

@@ hdl/bsc_cfg_regs.sv @@
`default_nettype none

module bsc_cfg_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [2:0]        wr_index,
	input  wire logic [15:0]       wr_data,
	output bsc_pkg::cal_cfg_t      cfg
);
	import bsc_pkg::*;

	cal_cfg_t cfg_q;

	// Write one calibration register per beat, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sens      <= '0;
			cfg_q.off       <= '0;
			cfg_q.sens_tc   <= '0;
			cfg_q.off_tc    <= '0;
			cfg_q.tref      <= '0;
			cfg_q.temp_sens <= '0;
			cfg_q.so_en     <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				REG_SENS:      cfg_q.sens      <= wr_data;
				REG_OFF:       cfg_q.off       <= wr_data;
				REG_SENS_TC:   cfg_q.sens_tc   <= wr_data;
				REG_OFF_TC:    cfg_q.off_tc    <= wr_data;
				REG_TREF:      cfg_q.tref      <= wr_data;
				REG_TEMP_SENS: cfg_q.temp_sens <= wr_data;
				REG_SO_EN:     cfg_q.so_en     <= wr_data[0];
				default:       ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/bsc_first_order.sv @@
`default_nettype none

module bsc_first_order #(
	parameter int RAW_BITS = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire bsc_pkg::cal_cfg_t          cfg,
	input  wire logic                       in_vld,
	input  wire logic [bsc_pkg::IN_W-1:0]   d1_in,
	input  wire logic [bsc_pkg::IN_W-1:0]   d2_in,
	output logic                            out_vld,
	output bsc_pkg::fo_t                    out_data
);
	import bsc_pkg::*;

	localparam logic [IN_W-1:0] RAW_MASK = IN_W'((25'd1 << RAW_BITS) - 25'd1);

	// Stage 1: dT
	logic                     vld_s1;
	logic [IN_W-1:0]          d1_s1;
	logic signed [DT_W-1:0]   dt_s1;

	// Stage 2: products with dT
	logic                     vld_s2;
	logic [IN_W-1:0]          d1_s2;
	logic signed [41:0]       pt_s2;
	logic signed [41:0]       po_s2;
	logic signed [41:0]       ps_s2;
	logic signed [49:0]       pdd_s2;

	// Stage 3: first-order terms
	logic                     vld_s3;
	fo_t                      fo_s3;

	logic [IN_W-1:0]          d1_m;
	logic [IN_W-1:0]          d2_m;
	logic signed [DT_W-1:0]   dt_c;
	logic signed [41:0]       pt_div;
	logic signed [41:0]       po_div;
	logic signed [41:0]       ps_div;
	logic signed [OS_W-1:0]   off_base;
	logic signed [OS_W-1:0]   sens_base;

	assign d1_m = d1_in & RAW_MASK;
	assign d2_m = d2_in & RAW_MASK;
	assign dt_c = $signed({1'b0, d2_m}) - $signed({1'b0, cfg.tref, 8'b0});

	// Truncate toward zero: bias negative values before the shift
	assign pt_div = (pt_s2 + (pt_s2[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
	assign po_div = (po_s2 + (po_s2[41] ? 42'sd127 : 42'sd0)) >>> 7;
	assign ps_div = (ps_s2 + (ps_s2[41] ? 42'sd255 : 42'sd0)) >>> 8;

	assign off_base  = $signed({8'b0, cfg.off, 16'b0});
	assign sens_base = $signed({9'b0, cfg.sens, 15'b0});

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= d1_m;
			dt_s1 <= dt_c;

			d1_s2  <= d1_s1;
			pt_s2  <= dt_s1 * $signed({1'b0, cfg.temp_sens});
			po_s2  <= dt_s1 * $signed({1'b0, cfg.off_tc});
			ps_s2  <= dt_s1 * $signed({1'b0, cfg.sens_tc});
			pdd_s2 <= dt_s1 * dt_s1;

			fo_s3.d1   <= d1_s2;
			fo_s3.temp <= $signed(pt_div[TEMP_W-1:0]) + TEMP_REF;
			fo_s3.t2   <= {1'b0, pdd_s2[49:31]};
			fo_s3.off  <= off_base + $signed(po_div[OS_W-1:0]);
			fo_s3.sens <= sens_base + $signed(ps_div[OS_W-1:0]);
		end
	end

	assign out_vld  = vld_s3;
	assign out_data = fo_s3;

endmodule

`default_nettype wire

@@ hdl/bsc_second_order.sv @@
`default_nettype none

module bsc_second_order (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          so_en,
	input  wire logic          in_vld,
	input  wire bsc_pkg::fo_t  in_data,
	output logic               out_vld,
	output bsc_pkg::so_t       out_data
);
	import bsc_pkg::*;

	// Stage 4: squares of the temperature deviations
	logic                     vld_s4;
	logic [IN_W-1:0]          d1_s4;
	logic signed [TEMP_W-1:0] temp_s4;
	logic signed [OS_W-1:0]   off_s4;
	logic signed [OS_W-1:0]   sens_s4;
	logic [OS_W-1:0]          lo2_s4;
	logic [OS_W-1:0]          vlo2_s4;
	logic                     low_s4;
	logic                     very_s4;

	// Stage 5: corrected OFF and SENS
	logic                     vld_s5;
	so_t                      so_s5;

	logic signed [TEMP_W-1:0] lo;
	logic signed [TEMP_W-1:0] vlo;
	logic signed [OS_W-1:0]   lo2_c;
	logic signed [OS_W-1:0]   vlo2_c;
	logic                     low_c;
	logic [OS_W-1:0]          lo5;
	logic [OS_W-1:0]          off2;
	logic [OS_W-1:0]          sens2;

	assign lo     = in_data.temp - TEMP_REF;
	assign vlo    = in_data.temp - TEMP_VERY_LOW;
	assign lo2_c  = lo * lo;
	assign vlo2_c = vlo * vlo;
	assign low_c  = so_en && (in_data.temp < TEMP_REF);

	// Squares are non-negative, so plain shifts truncate correctly
	assign lo5   = (lo2_s4 << 2) + lo2_s4;
	assign off2  = (lo5 >> 1) + (very_s4 ? ((vlo2_s4 << 3) - vlo2_s4) : '0);
	assign sens2 = (lo5 >> 2)
		+ (very_s4 ? (((vlo2_s4 << 3) + (vlo2_s4 << 1) + vlo2_s4) >> 1) : '0);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_vld;
			vld_s5 <= vld_s4;
		end
	end

	// Advance payload, apply corrections only in the low-temperature range
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s4   <= in_data.d1;
			temp_s4 <= low_c ? (in_data.temp - $signed(in_data.t2)) : in_data.temp;
			off_s4  <= in_data.off;
			sens_s4 <= in_data.sens;
			lo2_s4  <= lo2_c;
			vlo2_s4 <= vlo2_c;
			low_s4  <= low_c;
			very_s4 <= low_c && (in_data.temp < TEMP_VERY_LOW);

			so_s5.d1   <= d1_s4;
			so_s5.temp <= temp_s4;
			so_s5.off  <= low_s4 ? (off_s4 - $signed(off2)) : off_s4;
			so_s5.sens <= low_s4 ? (sens_s4 - $signed(sens2)) : sens_s4;
		end
	end

	assign out_vld  = vld_s5;
	assign out_data = so_s5;

endmodule

`default_nettype wire

@@ hdl/bsc_pressure.sv @@
`default_nettype none

module bsc_pressure (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire bsc_pkg::so_t  in_data,
	output logic               out_vld,
	output bsc_pkg::res_t      out_data
);
	import bsc_pkg::*;

	// Stage 6: split D1*SENS into two partial products
	logic                     vld_s6;
	logic signed [44:0]       ph_s6;
	logic [43:0]              pl_s6;
	logic signed [OS_W-1:0]   off_s6;
	logic signed [TEMP_W-1:0] temp_s6;

	// Stage 7: D1*SENS/2^21 - OFF
	logic                     vld_s7;
	logic signed [44:0]       p1_s7;
	logic signed [TEMP_W-1:0] temp_s7;

	// Stage 8: output register
	logic                     vld_s8;
	res_t                     res_s8;

	logic signed [63:0]       prod;
	logic signed [63:0]       prod_div;
	logic signed [44:0]       p_div;

	assign prod     = (64'(ph_s6) <<< 20) + $signed({20'b0, pl_s6});
	assign prod_div = (prod + (prod[63] ? 64'sd2097151 : 64'sd0)) >>> 21;
	assign p_div    = (p1_s7 + (p1_s7[44] ? 45'sd32767 : 45'sd0)) >>> 15;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s6 <= in_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Advance payload, clamp pressure at the output stage
	always_ff @(posedge clk) begin
		if (en) begin
			ph_s6   <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[OS_W-1:20]);
			pl_s6   <= in_data.d1 * in_data.sens[19:0];
			off_s6  <= in_data.off;
			temp_s6 <= in_data.temp;

			p1_s7   <= $signed(prod_div[44:0]) - 45'(off_s6);
			temp_s7 <= temp_s6;

			res_s8.temp <= temp_s7;
			if (p_div[44]) begin
				res_s8.pressure <= '0;
				res_s8.sat      <= 1'b1;
			end else if (p_div > $signed({21'b0, PRESSURE_MAX})) begin
				res_s8.pressure <= PRESSURE_MAX;
				res_s8.sat      <= 1'b1;
			end else begin
				res_s8.pressure <= p_div[P_W-1:0];
				res_s8.sat      <= 1'b0;
			end
		end
	end

	assign out_vld  = vld_s8;
	assign out_data = res_s8;

endmodule

`default_nettype wire

@@ hdl/barometer_sensor_compensation.sv @@
`default_nettype none
// Stages: an accepted input beat passes in order through dT, products, first
// order, squares, corrections, partial products, pressure difference, output
// register. Throughput: one beat per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: arst_n clears all valid bits, calibration words to 0, second order on.

module barometer_sensor_compensation #(
	parameter int RAW_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [23:0] raw_pressure,
	input  wire logic [23:0] raw_temperature,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [23:0]      pressure,
	output logic [19:0]      temperature,
	output logic             pressure_saturated,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import bsc_pkg::*;

	cal_cfg_t cfg;
	logic     en;
	logic     fo_vld;
	fo_t      fo_data;
	logic     so_vld;
	so_t      so_data;
	logic     res_vld;
	res_t     res_data;

	// Advance every stage unless a finished beat waits at the output
	assign en        = !res_vld || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	bsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bsc_first_order #(
		.RAW_BITS (RAW_BITS)
	) u_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg),
		.in_vld   (in_valid),
		.d1_in    (raw_pressure),
		.d2_in    (raw_temperature),
		.out_vld  (fo_vld),
		.out_data (fo_data)
	);

	bsc_second_order u_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.so_en    (cfg.so_en),
		.in_vld   (fo_vld),
		.in_data  (fo_data),
		.out_vld  (so_vld),
		.out_data (so_data)
	);

	bsc_pressure u_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (so_vld),
		.in_data  (so_data),
		.out_vld  (res_vld),
		.out_data (res_data)
	);

	assign out_valid          = res_vld;
	assign pressure           = res_data.pressure;
	assign temperature        = res_data.temp;
	assign pressure_saturated = res_data.sat;

endmodule

`default_nettype wire

@@ sim/tb_barometer_sensor_compensation.sv @@
`default_nettype none

module tb_barometer_sensor_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	import bsc_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int         LATENCY    = 8;
	localparam int         SETTLE     = LATENCY + 4;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         MAX_REPORTS = 60;
	localparam longint     T2_DIV     = 64'sd2147483648;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [23:0] raw_pressure = '0;
	logic [23:0] raw_temperature = '0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = REG_SENS;
	logic [15:0] cfg_data = '0;
	logic        in_ready;
	logic        out_valid;
	logic        cfg_ready;
	logic [23:0] pressure;
	logic [19:0] temperature;
	logic        pressure_saturated;

	// Calibration as the block should see it, and readings still owed
	cal_cfg_t cal_shadow;
	res_t     pending_readings[$];

	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned n_cold = 0;
	int unsigned n_clamped = 0;
	int unsigned n_cal_sets = 0;

	logic        rx_stall_en = 1'b1;
	int unsigned rx_left = 0;

	barometer_sensor_compensation u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.raw_pressure       (raw_pressure),
		.raw_temperature    (raw_temperature),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.pressure           (pressure),
		.temperature        (temperature),
		.pressure_saturated (pressure_saturated),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always #5 clk = ~clk;

	// Predict one compensated reading; all divisions truncate toward zero
	function automatic res_t compensate(cal_cfg_t c, logic [23:0] raw_p, logic [23:0] raw_t);
		longint d1, dt, temp_fo, temp_c, off, sens, lo, vlo, off2, sens2, p;
		res_t   r;
		d1      = longint'(raw_p);
		dt      = longint'(raw_t) - longint'(c.tref) * 256;
		temp_fo = 2000 + dt * longint'(c.temp_sens) / 8388608;
		off     = longint'(c.off) * 65536 + longint'(c.off_tc) * dt / 128;
		sens    = longint'(c.sens) * 32768 + longint'(c.sens_tc) * dt / 256;
		temp_c  = temp_fo;
		// Low-temperature corrections, all from the first-order temperature
		if (c.so_en && temp_fo < 2000) begin
			lo    = temp_fo - 2000;
			off2  = 5 * (lo * lo) / 2;
			sens2 = 5 * (lo * lo) / 4;
			if (temp_fo < -1500) begin
				vlo   = temp_fo + 1500;
				off2  = off2 + 7 * (vlo * vlo);
				sens2 = sens2 + 11 * (vlo * vlo) / 2;
			end
			temp_c = temp_fo - dt * dt / T2_DIV;
			off    = off - off2;
			sens   = sens - sens2;
		end
		p = (d1 * sens / 2097152 - off) / 32768;
		// Clamp pressure to the 24-bit output range
		r.sat      = (p < 0) || (p > 16777215);
		r.pressure = (p < 0) ? '0 : ((p > 16777215) ? PRESSURE_MAX : p[23:0]);
		r.temp     = temp_c[19:0];
		return r;
	endfunction

	function automatic cal_cfg_t make_cal(logic [15:0] sens, logic [15:0] off,
		logic [15:0] sens_tc, logic [15:0] off_tc, logic [15:0] tref,
		logic [15:0] temp_sens, logic so_en);
		cal_cfg_t c;
		c.sens      = sens;
		c.off       = off;
		c.sens_tc   = sens_tc;
		c.off_tc    = off_tc;
		c.tref      = tref;
		c.temp_sens = temp_sens;
		c.so_en     = so_en;
		return c;
	endfunction

	function automatic void check_field(string what, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Predict on each accepted input beat, check each accepted output beat
	always @(posedge clk) begin : scoreboard
		res_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pending_readings.push_back(compensate(cal_shadow, raw_pressure, raw_temperature));
				n_sent++;
			end
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected output beat: pressure %0d, temperature %0d",
						$time, pressure, $signed(temperature));
				end else begin
					want = pending_readings.pop_front();
					n_checked++;
					if (want.temp < TEMP_REF)
						n_cold++;
					if (want.sat)
						n_clamped++;
					check_field("pressure", want.pressure, pressure);
					check_field("temperature", want.temp, $signed(temperature));
					check_field("pressure_saturated", want.sat, pressure_saturated);
				end
			end
		end
	end

	// Stall the output side in runs of random length, with long ready stretches
	always @(posedge clk) begin
		if (rx_left != 0) begin
			rx_left <= rx_left - 1;
		end else if (!rx_stall_en || !out_ready) begin
			out_ready <= 1'b1;
			rx_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 10);
		end else begin
			out_ready <= 1'b0;
			rx_left   <= $urandom_range(0, 6);
		end
	end

	// Abort a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d readings still owed", CYCLE_LIMIT,
			pending_readings.size());
		$display("TB_ERROR");
		$finish;
	end

	// Present one beat and hold it until taken; valid stays high afterwards
	task automatic send_reading(logic [23:0] p, logic [23:0] t);
		in_valid        <= 1'b1;
		raw_pressure    <= p;
		raw_temperature <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Wait for every owed reading, then let the pipeline empty
	task automatic wait_idle();
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cal_reg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SENS:      cal_shadow.sens      = data;
			REG_OFF:       cal_shadow.off       = data;
			REG_SENS_TC:   cal_shadow.sens_tc   = data;
			REG_OFF_TC:    cal_shadow.off_tc    = data;
			REG_TREF:      cal_shadow.tref      = data;
			REG_TEMP_SENS: cal_shadow.temp_sens = data;
			REG_SO_EN:     cal_shadow.so_en     = data[0];
			default: ;
		endcase
	endtask

	// Reprogram all calibration words while idle; poke the unused index too
	task automatic load_cal(cal_cfg_t c);
		logic [31:0] r;
		wait_idle();
		r = $urandom;
		write_cal_reg(REG_UNUSED, r[15:0]);
		write_cal_reg(REG_SENS, c.sens);
		write_cal_reg(REG_OFF, c.off);
		write_cal_reg(REG_SENS_TC, c.sens_tc);
		write_cal_reg(REG_OFF_TC, c.off_tc);
		write_cal_reg(REG_TREF, c.tref);
		write_cal_reg(REG_TEMP_SENS, c.temp_sens);
		write_cal_reg(REG_SO_EN, {r[31:17], c.so_en});
		cfg_valid <= 1'b0;
		n_cal_sets++;
	endtask

	// Random readings, in bursts when with_gaps is set; many temperatures land near the reference point
	task automatic run_readings(int unsigned count, bit with_gaps);
		int unsigned burst;
		logic [31:0] r;
		longint      t;
		burst = $urandom_range(1, 16);
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom;
			case ($urandom_range(0, 9))
				0: t = r[0] ? 16777215 : 0;
				1, 2, 3: begin
					t = longint'(cal_shadow.tref) * 256
						+ longint'($urandom_range(0, 2097152)) - 1048576;
					if (t < 0)
						t = 0;
					else if (t > 16777215)
						t = 16777215;
				end
				default: t = longint'(r[23:0]);
			endcase
			r = $urandom;
			send_reading((r[31:29] == 3'd0) ? {24{r[28]}} : r[23:0], t[23:0]);
			if (with_gaps) begin
				burst--;
				if (burst == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
					burst = $urandom_range(1, 16);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	// Zero calibration after reset: flat 20.00 degC and zero pressure
	task automatic test_reset_state();
		send_reading(24'h000000, 24'h000000);
		send_reading(24'hFFFFFF, 24'hFFFFFF);
		send_reading(24'h800000, 24'h7FFFFF);
		send_reading(24'hAAAAAA, 24'h555555);
		in_valid <= 1'b0;
	endtask

	// Typical factory words across the raw extremes
	task automatic test_calibrated_extremes();
		load_cal(make_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464,
			16'd28312, 1'b1));
		send_reading(24'd9085466, 24'd8569150);
		send_reading(24'h000000, 24'h000000);
		send_reading(24'hFFFFFF, 24'hFFFFFF);
		send_reading(24'hFFFFFF, 24'h000000);
		send_reading(24'h000000, 24'hFFFFFF);
		in_valid <= 1'b0;
	endtask

	// Temperature is 2000 + dT/256 here: hit both thresholds and truncation
	task automatic test_temperature_thresholds();
		load_cal(make_cal(16'd40000, 16'd30000, 16'd20000, 16'd20000, 16'd8000,
			16'd32768, 1'b1));
		send_reading(24'd8000000, 24'd2048000);
		send_reading(24'd8000000, 24'd2047745);
		send_reading(24'd8000000, 24'd2047744);
		send_reading(24'd8000000, 24'd1152000);
		send_reading(24'd8000000, 24'd1151745);
		send_reading(24'd8000000, 24'd1151744);
		in_valid <= 1'b0;
	endtask

	// Same cold points with the corrections switched off
	task automatic test_second_order_disabled();
		load_cal(make_cal(16'd40000, 16'd30000, 16'd20000, 16'd20000, 16'd8000,
			16'd32768, 1'b0));
		send_reading(24'd8000000, 24'd2047744);
		send_reading(24'd8000000, 24'd1151744);
		send_reading(24'hFFFFFF, 24'h000000);
		send_reading(24'h000000, 24'h000000);
		in_valid <= 1'b0;
	endtask

	// Drive pressure below zero, then push everything to full scale
	task automatic test_pressure_saturation();
		load_cal(make_cal(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
		send_reading(24'hFFFFFF, 24'h000000);
		send_reading(24'h000000, 24'hFFFFFF);
		in_valid <= 1'b0;
		load_cal(make_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		send_reading(24'hFFFFFF, 24'hFFFFFF);
		send_reading(24'h000000, 24'h000000);
		send_reading(24'hFFFFFF, 24'h000000);
		in_valid <= 1'b0;
	endtask

	// Random readings under extreme, typical and random calibration sets
	task automatic test_random_readings();
		cal_cfg_t    c;
		logic [31:0] r0, r1, r2, r3;
		for (int ph = 0; ph < 6; ph++) begin
			r0 = $urandom;
			r1 = $urandom;
			r2 = $urandom;
			r3 = $urandom;
			case (ph)
				0: c = make_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
				1: c = make_cal(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
				2: c = make_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464,
					16'd28312, r3[0]);
				default: c = make_cal(r0[15:0], r0[31:16], r1[15:0], r1[31:16], r2[15:0],
					r2[31:16], r3[0]);
			endcase
			load_cal(c);
			rx_stall_en <= (ph != 3);
			run_readings(85, ph != 4);
		end
	endtask

	initial begin : main
		cal_shadow       = '0;
		cal_shadow.so_en = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_calibrated_extremes();
		test_temperature_thresholds();
		test_second_order_disabled();
		test_pressure_saturation();
		test_random_readings();
		wait_idle();
		$display("Compared %0d of %0d readings over %0d calibration sets", n_checked, n_sent,
			n_cal_sets);
		$display("%0d below 20 degC, %0d pressure clamps, %0d field mismatches", n_cold,
			n_clamped, n_errors);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ barometer_sensor_compensation.f @@
hdl/bsc_pkg.sv
hdl/bsc_cfg_regs.sv
hdl/bsc_first_order.sv
hdl/bsc_second_order.sv
hdl/bsc_pressure.sv
hdl/barometer_sensor_compensation.sv
sim/tb_barometer_sensor_compensation.sv
